// ----- src/atpa_pkg.sv -----
// ----------------------------------------------------------------------------
// atpa_pkg
// Shared types, fixed-point constants and rounding helper for the atan2 core.
// ----------------------------------------------------------------------------
package atpa_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int ANGLE_FRAC_DEF  = 13;

	localparam int RATIO_FRAC = 15;
	localparam int POLY_FRAC  = 30;
	localparam int QBITS      = RATIO_FRAC + 2;  // one extra bit for rounding
	localparam int ACC_W      = 32;
	localparam int ANGLE_W    = 16;
	localparam int TOT_W      = 35;

	// odd polynomial coefficients a1..a11, 30 fraction bits
	localparam logic signed [ACC_W-1:0] POLY_COEF [0:5] = '{
		32'sd1073717407,
		-32'sd357151731,
		32'sd207815708,
		-32'sd125018842,
		32'sd56536072,
		-32'sd12585543
	};

	localparam logic signed [TOT_W-1:0] FX_PI      = 35'sd3373259426;
	localparam logic signed [TOT_W-1:0] FX_HALF_PI = 35'sd1686629713;

	typedef struct packed {
		logic ysign;
		logic xneg;
		logic swap;
		logic rneg;
		logic origin;
	} side_t;

	// arithmetic shift right by s, rounded half away from zero
	function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
		input int unsigned s);
		logic signed [63:0] h;
		logic signed [63:0] b;
		h = 64'sd1 <<< (s - 1);
		b = v[63] ? 64'sd1 : 64'sd0;
		return (v + h - b) >>> s;
	endfunction

endpackage

// ----- src/atpa_div.sv -----
// ----------------------------------------------------------------------------
// atpa_div
// Restoring divider, one quotient bit per stage: floor(mn * 2^16 / md).
// ----------------------------------------------------------------------------
module atpa_div import atpa_pkg::*; #(
	parameter int W = COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [W-1:0]        mn,
	input  logic [W-1:0]        md,
	input  side_t               side_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [QBITS-1:0]    q,
	output side_t               side_out
);

	localparam int NS = QBITS;

	logic [NS-1:0]    v_s;
	logic [NS:0]      en;
	logic [W-1:0]     rem_s  [NS];
	logic [W-1:0]     md_s   [NS];
	logic [QBITS-1:0] q_s    [NS];
	side_t            side_s [NS];

	assign en[NS] = out_ready;

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic             vin;
		logic [W:0]       trial;
		logic [W-1:0]     md_in;
		logic [QBITS-1:0] q_in;
		side_t            sd_in;
		logic             ge;

		if (i == 0) begin : g_first
			assign vin   = in_valid;
			assign trial = {1'b0, mn};
			assign md_in = md;
			assign q_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign vin   = v_s[i-1];
			assign trial = {rem_s[i-1], 1'b0};
			assign md_in = md_s[i-1];
			assign q_in  = q_s[i-1];
			assign sd_in = side_s[i-1];
		end

		assign ge    = trial >= {1'b0, md_in};
		assign en[i] = !v_s[i] || en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en[i]) begin
				v_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i]  <= ge ? W'(trial - {1'b0, md_in}) : trial[W-1:0];
				md_s[i]   <= md_in;
				q_s[i]    <= {q_in[QBITS-2:0], ge};
				side_s[i] <= sd_in;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[NS-1];
	assign q         = q_s[NS-1];
	assign side_out  = side_s[NS-1];

endmodule

// ----- src/atpa_poly.sv -----
// ----------------------------------------------------------------------------
// atpa_poly
// Ratio rounding, Horner evaluation of the odd polynomial, quadrant fixup.
// ----------------------------------------------------------------------------
module atpa_poly import atpa_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [QBITS-1:0]    q,
	input  side_t               side_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ANGLE_W-1:0]  angle,
	output logic                origin_flag
);

	// stage map: 0 ratio, 1 square, 2..11 Horner (mult, round+add),
	// 12 final mult, 13 round, 14 quadrant, 15 output
	localparam int NS     = 16;
	localparam int NSTEP  = 5;
	localparam int S_PM   = 12;
	localparam int S_P    = 13;
	localparam int S_TOT  = 14;
	localparam int FSHIFT = POLY_FRAC - ANGLE_FRAC_BITS;

	logic [NS-1:0]           v_s;
	logic [NS:0]             en;
	side_t                   side_s [NS];
	logic signed [16:0]      r_s    [NS];
	logic [POLY_FRAC:0]      r2_s   [NS];

	logic signed [63:0]      prod_s [NSTEP];
	logic signed [ACC_W-1:0] acc_s  [NSTEP];
	logic signed [48:0]      pm_s12;
	logic signed [ACC_W-1:0] p_s13;
	logic signed [TOT_W-1:0] tot_s14;
	logic [ANGLE_W-1:0]      angle_s15;

	logic [RATIO_FRAC+1:0]   qr;
	logic signed [16:0]      r_calc;
	logic signed [33:0]      r_sq;

	assign qr     = (RATIO_FRAC+2)'(({1'b0, q} + (QBITS+1)'(1)) >> 1);
	assign r_calc = side_in.rneg ? $signed(17'(0) - qr) : $signed(qr);
	assign r_sq   = r_s[0] * r_s[0];

	assign en[NS] = out_ready;

	// valid chain and values carried alongside every stage
	for (genvar i = 0; i < NS; i++) begin : g_pipe
		logic               vin;
		side_t              sd_in;
		logic signed [16:0] r_in;
		logic [POLY_FRAC:0] r2_in;

		if (i == 0) begin : g_first
			assign vin   = in_valid;
			assign sd_in = side_in;
			assign r_in  = r_calc;
			assign r2_in = '0;
		end else if (i == 1) begin : g_sq
			assign vin   = v_s[0];
			assign sd_in = side_s[0];
			assign r_in  = r_s[0];
			assign r2_in = r_sq[POLY_FRAC:0];
		end else begin : g_carry
			assign vin   = v_s[i-1];
			assign sd_in = side_s[i-1];
			assign r_in  = r_s[i-1];
			assign r2_in = r2_s[i-1];
		end

		assign en[i] = !v_s[i] || en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en[i]) begin
				v_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				side_s[i] <= sd_in;
				r_s[i]    <= r_in;
				r2_s[i]   <= r2_in;
			end
		end
	end

	// Horner: acc = c11, then acc = c_k + rnd(acc * r2 >> 30)
	for (genvar k = 0; k < NSTEP; k++) begin : g_horner
		logic signed [ACC_W-1:0] acc_in;
		logic signed [ACC_W-1:0] r2_sg;
		logic signed [63:0]      pm;

		if (k == 0) begin : g_c11
			assign acc_in = POLY_COEF[NSTEP];
		end else begin : g_acc
			assign acc_in = acc_s[k-1];
		end

		assign r2_sg = $signed({1'b0, r2_s[1+2*k]});
		assign pm    = acc_in * r2_sg;

		always_ff @(posedge clk) begin
			if (en[2+2*k]) begin
				prod_s[k] <= pm;
			end
		end

		always_ff @(posedge clk) begin
			if (en[3+2*k]) begin
				acc_s[k] <= POLY_COEF[NSTEP-1-k] + ACC_W'(rnd_sh(prod_s[k], POLY_FRAC));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_PM]) begin
			pm_s12 <= acc_s[NSTEP-1] * r_s[S_PM-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_P]) begin
			p_s13 <= ACC_W'(rnd_sh(64'(pm_s12), RATIO_FRAC));
		end
	end

	// quadrant fixup
	logic signed [TOT_W-1:0] base;
	logic signed [TOT_W-1:0] p_ext;
	side_t                   sd_t;

	assign sd_t  = side_s[S_TOT-1];
	assign p_ext = TOT_W'(p_s13);

	always_comb begin
		if (sd_t.swap) begin
			base = sd_t.ysign ? -FX_HALF_PI : FX_HALF_PI;
		end else if (sd_t.xneg) begin
			base = sd_t.ysign ? -FX_PI : FX_PI;
		end else begin
			base = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_TOT]) begin
			tot_s14 <= sd_t.swap ? base - p_ext : base + p_ext;
		end
	end

	logic signed [63:0] fin;
	assign fin = rnd_sh(64'(tot_s14), FSHIFT);

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			angle_s15 <= side_s[NS-2].origin ? '0 : fin[ANGLE_W-1:0];
		end
	end

	assign in_ready    = en[0];
	assign out_valid   = v_s[NS-1];
	assign angle       = angle_s15;
	assign origin_flag = side_s[NS-1].origin;

endmodule

// ----- src/atan2_polynomial_approx_core.sv -----
// Pipeline: an input beat passes 1 magnitude stage, 17 divider stages and
// 16 polynomial stages on its way to the output beat.
// Throughput: one beat per cycle while out_ready is high; every stage holds its
// own valid bit and a stalled output only backs up stages that already hold data.
// Reset: arst_n clears all valid bits asynchronously; data registers keep
// whatever they held.
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_core
// Four-quadrant arctangent of (coord_y, coord_x), Q3.13 radians by default.
// ----------------------------------------------------------------------------
module atan2_polynomial_approx_core import atpa_pkg::*; #(
	parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COORD_WIDTH-1:0] coord_y,
	input  logic [COORD_WIDTH-1:0] coord_x,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ANGLE_W-1:0]     angle,
	output logic                   origin_flag
);

	localparam int W = COORD_WIDTH;

	// Front stage: magnitudes, octant swap and sign bookkeeping.
	// |min| over |max| is always <= 1, so the quotient fits Q1.15 after rounding.
	logic [W-1:0] ay, ax, mn, md;
	logic         swap;
	side_t        side_d;

	assign ay   = coord_y[W-1] ? W'(-coord_y) : coord_y;
	assign ax   = coord_x[W-1] ? W'(-coord_x) : coord_x;
	assign swap = ax < ay;
	assign mn   = swap ? ax : ay;
	assign md   = swap ? ay : ax;

	// ratio sign is sign(y) xor sign(x) whichever way round the division goes;
	// a zero numerator gives a zero ratio so its sign is moot
	assign side_d.ysign  = coord_y[W-1];
	assign side_d.xneg   = coord_x[W-1];
	assign side_d.swap   = swap;
	assign side_d.rneg   = coord_y[W-1] ^ coord_x[W-1];
	assign side_d.origin = (md == '0);

	logic         v_s1;
	logic [W-1:0] mn_s1, md_s1;
	side_t        side_s1;
	logic         en_s1;
	logic         div_ready;

	assign en_s1    = !v_s1 || div_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mn_s1   <= mn;
			md_s1   <= md;
			side_s1 <= side_d;
		end
	end

	// Divider: 17 quotient bits, the last one used for round-half-up
	logic             div_valid, poly_ready;
	logic [QBITS-1:0] div_q;
	side_t            div_side;

	atpa_div #(
		.W (W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (div_ready),
		.mn        (mn_s1),
		.md        (md_s1),
		.side_in   (side_s1),
		.out_valid (div_valid),
		.out_ready (poly_ready),
		.q         (div_q),
		.side_out  (div_side)
	);

	// Polynomial and quadrant fixup; its last stage is the output register
	atpa_poly #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_poly (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_valid),
		.in_ready    (poly_ready),
		.q           (div_q),
		.side_in     (div_side),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.angle       (angle),
		.origin_flag (origin_flag)
	);

endmodule

// ----- src/atpa_checker.sv -----
// ----------------------------------------------------------------------------
// atpa_checker
// Port-level checks for the atan2 core, bound to the top level.
// ----------------------------------------------------------------------------
module atpa_checker import atpa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ANGLE_W-1:0] angle,
	input logic               origin_flag
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(origin_flag))
		else $error("output beat changed while stalled");

	// origin beat carries a zero angle
	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && origin_flag |-> angle == '0)
		else $error("origin beat with nonzero angle");

	// with the output stage empty nothing can back up to the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// right after reset the output stage is empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind atan2_polynomial_approx_core atpa_checker u_atpa_checker (.*);
